>>> rtl/breath_cycle_sequencer_defines.svh
// Assertion macros shared by the breath cycle sequencer checker.
`ifndef BREATH_CYCLE_SEQUENCER_DEFINES_SVH
`define BREATH_CYCLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bcs_pkg.sv
// Types, codes and constant tables of the breath cycle sequencer.
`default_nettype none

package bcs_pkg;

  localparam int unsigned INSP_PERCENT     = 33;
  localparam int unsigned EXP_PERCENT      = 67;
  localparam int unsigned CURRENT_LIMIT_MA = 4500;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_RESET = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_INSP   = 3'd2,
    PH_HOLD   = 3'd3,
    PH_EXP    = 3'd4,
    PH_TOIDLE = 3'd5
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PEAK_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_VOLUME_INDEX = 3'd1;
  localparam logic [2:0] CFG_RATE_INDEX   = 3'd2;
  localparam logic [2:0] CFG_OPEN_POS     = 3'd3;
  localparam logic [2:0] CFG_IDLE_POS     = 3'd4;
  localparam logic [2:0] CFG_PLATEAU_MS   = 3'd5;
  localparam logic [2:0] CFG_FAST_OPEN_MS = 3'd6;
  localparam logic [2:0] CFG_IDLE_MOVE_MS = 3'd7;

  localparam logic [12:0] NO_PLATEAU = 13'h1FFF;
  localparam logic [2:0]  MAX_INDEX  = 3'd5;
  localparam logic [7:0]  MAX_POS    = 8'd180;

  localparam logic [7:0] STROKE_TABLE [6] = '{8'd55, 8'd62, 8'd69, 8'd76, 8'd83, 8'd90};
  localparam int unsigned BPM_TABLE [6] = '{8, 10, 12, 14, 16, 18};

  // Phase spans per rate entry; the largest span stays well below 16 bits.
  localparam logic [15:0] INSP_SPAN [6] = '{
    16'(INSP_PERCENT * 60000 / (100 * BPM_TABLE[0])),
    16'(INSP_PERCENT * 60000 / (100 * BPM_TABLE[1])),
    16'(INSP_PERCENT * 60000 / (100 * BPM_TABLE[2])),
    16'(INSP_PERCENT * 60000 / (100 * BPM_TABLE[3])),
    16'(INSP_PERCENT * 60000 / (100 * BPM_TABLE[4])),
    16'(INSP_PERCENT * 60000 / (100 * BPM_TABLE[5]))
  };
  localparam logic [15:0] EXP_SPAN [6] = '{
    16'(EXP_PERCENT * 60000 / (100 * BPM_TABLE[0])),
    16'(EXP_PERCENT * 60000 / (100 * BPM_TABLE[1])),
    16'(EXP_PERCENT * 60000 / (100 * BPM_TABLE[2])),
    16'(EXP_PERCENT * 60000 / (100 * BPM_TABLE[3])),
    16'(EXP_PERCENT * 60000 / (100 * BPM_TABLE[4])),
    16'(EXP_PERCENT * 60000 / (100 * BPM_TABLE[5]))
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pressure_sample;
    logic [12:0] motor_current_ma;
    logic        motion_idle;
  } in_item_t;

  typedef struct packed {
    logic        command_valid;
    logic        command_force;
    logic [7:0]  target_position;
    logic [15:0] move_duration_ms;
    logic [2:0]  phase;
    logic [11:0] peak_pressure;
    logic [11:0] plateau_pressure;
  } out_item_t;

  function automatic logic [2:0] clamp_index(input logic [2:0] v);
    return (v > MAX_INDEX) ? MAX_INDEX : v;
  endfunction

  function automatic logic [7:0] clamp_pos(input logic [7:0] v);
    return (v > MAX_POS) ? MAX_POS : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/breath_cycle_sequencer.sv
// Breath cycle sequencer: pressure tracking, trip handling and phase stepping.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   in_      | in        | in_valid / in_stall  | in_data  (bcs_pkg::in_item_t)
//   out_     | out       | out_valid / out_stall| out_data (bcs_pkg::out_item_t)
//   cfg_     | in        | cfg_we               | cfg_index, cfg_wdata
//
// One beat in, one beat out; a new beat is taken every cycle unless out_stall holds the result register.
// A beat passes through the input register, then the result register.
// All event processing sits in one combinational pass between those registers.
// out_stall holds the result register and, through it, stalls the input side.
// rst_n is synchronous; it loads the configuration defaults and clears state.
`default_nettype none

module breath_cycle_sequencer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire bcs_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      bcs_pkg::out_item_t out_data,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);

  // Configuration registers.
  logic [11:0] peak_limit_r;
  logic [2:0]  volume_index_r;
  logic [2:0]  rate_index_r;
  logic [7:0]  open_pos_r;
  logic [7:0]  idle_pos_r;
  logic [15:0] plateau_ms_r;
  logic [15:0] fast_open_ms_r;
  logic [15:0] idle_move_ms_r;

  // Pipeline registers.
  logic               in_vld_r;
  bcs_pkg::in_item_t  in_r;
  logic               out_vld_r;
  bcs_pkg::out_item_t out_r;
  bcs_pkg::out_item_t out_nxt;

  // Sequencer state.
  logic [11:0]     filt_r, filt_nxt;
  logic [11:0]     rpeak_r, rpeak_nxt;
  logic [11:0]     lpeak_r, lpeak_nxt;
  logic [12:0]     rplat_r, rplat_nxt;
  logic [12:0]     lplat_r, lplat_nxt;
  bcs_pkg::phase_t phase_r, phase_nxt;
  logic            oper_r, oper_nxt;
  logic            fopen_r, fopen_nxt;
  logic [2:0]      arate_r, arate_nxt;
  logic [2:0]      avol_r, avol_nxt;

  logic        advance;
  logic [12:0] filt_sum;
  logic        trip;
  logic [15:0] hold_ms;
  logic [15:0] exp_ms;

  // Move the input beat into the result register when that slot frees up.
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign filt_sum = 13'(filt_r) + 13'(in_r.pressure_sample);

  always_comb begin
    filt_nxt  = filt_r;
    rpeak_nxt = rpeak_r;
    lpeak_nxt = lpeak_r;
    rplat_nxt = rplat_r;
    lplat_nxt = lplat_r;
    phase_nxt = phase_r;
    oper_nxt  = oper_r;
    fopen_nxt = fopen_r;
    arate_nxt = arate_r;
    avol_nxt  = avol_r;
    trip      = 1'b0;
    hold_ms   = plateau_ms_r;
    exp_ms    = bcs_pkg::EXP_SPAN[arate_r];
    out_nxt   = '0;

    unique case (in_r.kind)
      bcs_pkg::KIND_START: begin
        // Park at idle, queued behind the current move.
        phase_nxt                = bcs_pkg::PH_TOIDLE;
        oper_nxt                 = 1'b1;
        out_nxt.command_valid    = 1'b1;
        out_nxt.target_position  = bcs_pkg::clamp_pos(idle_pos_r);
        out_nxt.move_duration_ms = idle_move_ms_r;
      end
      bcs_pkg::KIND_STOP: begin
        // Abort to idle and drop the peak history.
        phase_nxt                = bcs_pkg::PH_TOIDLE;
        oper_nxt                 = 1'b0;
        rpeak_nxt                = '0;
        lpeak_nxt                = '0;
        out_nxt.command_valid    = 1'b1;
        out_nxt.command_force    = 1'b1;
        out_nxt.target_position  = bcs_pkg::clamp_pos(idle_pos_r);
        out_nxt.move_duration_ms = idle_move_ms_r;
      end
      bcs_pkg::KIND_RESET: begin
        phase_nxt = bcs_pkg::PH_TOIDLE;
        oper_nxt  = 1'b0;
      end
      bcs_pkg::KIND_TICK: begin
        filt_nxt = filt_sum[12:1];
        if (filt_nxt > rpeak_r) begin
          rpeak_nxt = filt_nxt;
        end
        if (phase_r == bcs_pkg::PH_EXP && {1'b0, filt_nxt} < rplat_r) begin
          rplat_nxt = {1'b0, filt_nxt};
        end
        trip = (phase_r != bcs_pkg::PH_INSP) &&
               ((filt_nxt >= peak_limit_r) ||
                (in_r.motor_current_ma > 13'(bcs_pkg::CURRENT_LIMIT_MA)));
        if (trip) begin
          // Fast open: force the arm open and jump to expiration (to-idle when not operating).
          phase_nxt                = bcs_pkg::PH_EXP;
          fopen_nxt                = 1'b1;
          out_nxt.command_valid    = 1'b1;
          out_nxt.command_force    = 1'b1;
          out_nxt.target_position  = bcs_pkg::clamp_pos(open_pos_r);
          out_nxt.move_duration_ms = fast_open_ms_r;
        end
        if (!oper_r && phase_nxt != bcs_pkg::PH_IDLE) begin
          phase_nxt = bcs_pkg::PH_TOIDLE;
        end
        if (!trip && in_r.motion_idle) begin
          unique case (phase_nxt)
            bcs_pkg::PH_IDLE: begin
              if (oper_r) begin
                phase_nxt                = bcs_pkg::PH_START;
                out_nxt.command_valid    = 1'b1;
                out_nxt.target_position  = bcs_pkg::clamp_pos(open_pos_r);
                out_nxt.move_duration_ms = idle_move_ms_r;
              end
            end
            bcs_pkg::PH_START: begin
              phase_nxt                = bcs_pkg::PH_INSP;
              out_nxt.command_valid    = 1'b1;
              out_nxt.target_position  = bcs_pkg::clamp_pos(open_pos_r);
              out_nxt.move_duration_ms = idle_move_ms_r;
            end
            bcs_pkg::PH_INSP: begin
              // Close out the breath and latch the settings for the next one.
              lplat_nxt                = rplat_nxt;
              rplat_nxt                = bcs_pkg::NO_PLATEAU;
              lpeak_nxt                = rpeak_nxt;
              rpeak_nxt                = '0;
              arate_nxt                = bcs_pkg::clamp_index(rate_index_r);
              avol_nxt                 = bcs_pkg::clamp_index(volume_index_r);
              phase_nxt                = bcs_pkg::PH_HOLD;
              out_nxt.command_valid    = 1'b1;
              out_nxt.target_position  = bcs_pkg::STROKE_TABLE[avol_nxt];
              out_nxt.move_duration_ms = bcs_pkg::INSP_SPAN[arate_nxt];
            end
            bcs_pkg::PH_HOLD: begin
              phase_nxt                = bcs_pkg::PH_EXP;
              out_nxt.command_valid    = 1'b1;
              out_nxt.target_position  = bcs_pkg::STROKE_TABLE[avol_r];
              out_nxt.move_duration_ms = plateau_ms_r;
            end
            bcs_pkg::PH_EXP: begin
              // A pending fast open already used up part of expiration.
              phase_nxt = bcs_pkg::PH_INSP;
              if (fopen_r) begin
                hold_ms   = fast_open_ms_r;
                fopen_nxt = 1'b0;
              end
              out_nxt.command_valid    = 1'b1;
              out_nxt.target_position  = bcs_pkg::clamp_pos(open_pos_r);
              out_nxt.move_duration_ms = (exp_ms > hold_ms) ? (exp_ms - hold_ms) : '0;
            end
            bcs_pkg::PH_TOIDLE: begin
              phase_nxt                = bcs_pkg::PH_IDLE;
              out_nxt.command_valid    = 1'b1;
              out_nxt.target_position  = bcs_pkg::clamp_pos(idle_pos_r);
              out_nxt.move_duration_ms = idle_move_ms_r;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    out_nxt.phase            = phase_nxt;
    out_nxt.peak_pressure    = (rpeak_nxt > lpeak_nxt) ? rpeak_nxt : lpeak_nxt;
    out_nxt.plateau_pressure = (lplat_nxt == bcs_pkg::NO_PLATEAU) ? 12'd0 : lplat_nxt[11:0];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_limit_r   <= 12'd640;
      volume_index_r <= 3'd0;
      rate_index_r   <= 3'd0;
      open_pos_r     <= 8'd0;
      idle_pos_r     <= 8'd0;
      plateau_ms_r   <= 16'd250;
      fast_open_ms_r <= 16'd100;
      idle_move_ms_r <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcs_pkg::CFG_PEAK_LIMIT:   peak_limit_r   <= cfg_wdata[11:0];
        bcs_pkg::CFG_VOLUME_INDEX: volume_index_r <= cfg_wdata[2:0];
        bcs_pkg::CFG_RATE_INDEX:   rate_index_r   <= cfg_wdata[2:0];
        bcs_pkg::CFG_OPEN_POS:     open_pos_r     <= cfg_wdata[7:0];
        bcs_pkg::CFG_IDLE_POS:     idle_pos_r     <= cfg_wdata[7:0];
        bcs_pkg::CFG_PLATEAU_MS:   plateau_ms_r   <= cfg_wdata;
        bcs_pkg::CFG_FAST_OPEN_MS: fast_open_ms_r <= cfg_wdata;
        bcs_pkg::CFG_IDLE_MOVE_MS: idle_move_ms_r <= cfg_wdata;
      endcase
    end
  end

  // Input register: load whenever the slot is empty or drains this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // Sequencer state: advance once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= '0;
      rpeak_r <= '0;
      lpeak_r <= '0;
      rplat_r <= bcs_pkg::NO_PLATEAU;
      lplat_r <= bcs_pkg::NO_PLATEAU;
      phase_r <= bcs_pkg::PH_TOIDLE;
      oper_r  <= 1'b0;
      fopen_r <= 1'b0;
      arate_r <= '0;
      avol_r  <= '0;
    end else if (advance) begin
      filt_r  <= filt_nxt;
      rpeak_r <= rpeak_nxt;
      lpeak_r <= lpeak_nxt;
      rplat_r <= rplat_nxt;
      lplat_r <= lplat_nxt;
      phase_r <= phase_nxt;
      oper_r  <= oper_nxt;
      fopen_r <= fopen_nxt;
      arate_r <= arate_nxt;
      avol_r  <= avol_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bcs_checker.sv
// Port-level checker for the breath cycle sequencer, bound to the top level.
`default_nettype none
`include "breath_cycle_sequencer_defines.svh"

module bcs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire bcs_pkg::out_item_t out_data
);

  `BCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `BCS_ASSERT_IMP(a_no_cmd_zero, out_valid && !out_data.command_valid, !out_data.command_force && out_data.target_position == 8'd0 && out_data.move_duration_ms == 16'd0, "idle result carries command fields")
  `BCS_ASSERT_IMP(a_target_range, out_valid && out_data.command_valid, out_data.target_position <= bcs_pkg::MAX_POS, "target position beyond 180 degrees")
  `BCS_ASSERT_IMP(a_force_phase, out_valid && out_data.command_force, out_data.phase == bcs_pkg::PH_EXP || out_data.phase == bcs_pkg::PH_TOIDLE, "forced move outside expire or to-idle phase")

endmodule

bind breath_cycle_sequencer bcs_checker u_bcs_checker (.*);

`default_nettype wire
